// ===== sv/pnv_pkg.sv =====
// Package for the per-head vector normalizer.
// Holds sizes, field widths and the sequencer state type; depends on nothing.
package pnv_pkg;
	localparam int HEAD_MAX   = 64;
	localparam int IDX_W      = $clog2(HEAD_MAX);
	localparam int LEN_W      = 7;
	localparam int ELEM_W     = 16;
	localparam int SUM_W      = 37;
	localparam int QUO_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int MANT_W     = 19;
	localparam int SH_W       = 4;
	localparam int SUB_W      = 39;
	localparam int PROD_W     = 36;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_SQRT,
		S_NORM,
		S_RD,
		S_MUL,
		S_OUT
	} pnv_state_t;
endpackage

// ===== sv/pnv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the element buffer of the normalizer.
module pnv_ram #(
	parameter int W = 16,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/per_head_vector_normalizer.sv =====
// Top level of the per-head RMS normalizer: buffer, sequencer and shared subtractor.
// Depends on pnv_pkg and pnv_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in       | in_valid / in_ready  | element_value (Q8.8)
//  cfg      | cfg_valid / cfg_ready| elems_per_head
//  out      | out_valid / out_ready| normalized_value (Q4.11), last_of_head
//
// Non-closing elements are taken while idle. A closing element of a head of n then runs
// a check, a divide and a root on the shared subtractor, a normalization, and for each
// emitted element a RAM read, a multiply and a round/saturate. A zero-sum head skips
// divide, root and normalize.
// Reset leaves the head length at 64, counters and sums at zero.
// A stalled output holds the emit sequence; input is refused until emit ends.
module per_head_vector_normalizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [pnv_pkg::ELEM_W-1:0] element_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pnv_pkg::LEN_W-1:0]       elems_per_head,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [pnv_pkg::ELEM_W-1:0] normalized_value,
	output logic                            last_of_head
);
	import pnv_pkg::*;

	pnv_state_t          state_q, state_d;
	logic [LEN_W-1:0]    len_q, len_eff;
	logic [IDX_W-1:0]    count_q, idx_q;
	logic [LEN_W-1:0]    n_q;
	logic [SUM_W-1:0]    sum_q;
	logic [QUO_W-1:0]    q_q;
	logic [SUM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [5:0]          iter_q;
	logic [MANT_W-1:0]   mant_q;
	logic [SH_W-1:0]     sh_q;
	logic [PROD_W-1:0]   prod_q;
	logic                neg_q;
	logic                out_valid_q, last_q;
	logic [ELEM_W-1:0]   out_q;

	logic                in_acc, closes, out_load, is_last;
	logic [ELEM_W-1:0]   mag_in, rd_mag, rdata;
	logic [SUB_W-1:0]    sub_a, sub_b, diff;
	logic                borrow;
	logic [4:0]          k;
	logic [PROD_W-1:0]   rnd, rounded;
	logic [ELEM_W:0]     res;
	logic [ELEM_W-1:0]   val;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign normalized_value = out_q;
	assign last_of_head = last_q;

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > LEN_W'(HEAD_MAX)) begin
			len_eff = LEN_W'(HEAD_MAX);
		end else begin
			len_eff = len_q;
		end
	end

	assign mag_in = element_value[ELEM_W-1] ? ELEM_W'(-element_value) : element_value;
	assign closes = ({1'b0, count_q} + LEN_W'(1)) >= len_eff;

	// shared compare-subtract unit for the divider and the root
	always_comb begin
		if (state_q == S_SQRT) begin
			sub_a = {2'b00, rem_q[34:0], q_q[QUO_W-1 -: 2]};
			sub_b = {5'b0, root_q, 2'b01};
		end else begin
			sub_a = {1'b0, rem_q, q_q[QUO_W-2]};
			sub_b = {2'b00, sum_q};
		end
		diff = sub_a - sub_b;
	end
	assign borrow = diff[SUB_W-1];

	pnv_ram #(.W(ELEM_W), .D(HEAD_MAX)) u_buf (
		.clk   (clk),
		.we    (in_acc),
		.waddr (count_q),
		.wdata (element_value),
		.re    (state_q == S_RD),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rd_mag = rdata[ELEM_W-1] ? ELEM_W'(-rdata) : rdata;

	// round half away from zero on magnitude, then saturate
	always_comb begin
		k       = 5'd17 - 5'(sh_q);
		rnd     = PROD_W'(1) << (k - 5'd1);
		rounded = (prod_q + rnd) >> k;
		if (neg_q) begin
			res = (rounded > PROD_W'(32768)) ? 17'd32768 : rounded[ELEM_W:0];
			val = ELEM_W'(17'h10000 - res);
		end else begin
			res = (rounded > PROD_W'(32767)) ? 17'd32767 : rounded[ELEM_W:0];
			val = res[ELEM_W-1:0];
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);
	assign is_last  = ({1'b0, idx_q} + LEN_W'(1)) == n_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_acc && closes) state_d = S_CHECK;
			S_CHECK: state_d = (sum_q == '0) ? S_RD : S_DIV;
			S_DIV:   if (iter_q == '0) state_d = S_SQRT;
			S_SQRT:  if (iter_q == '0) state_d = S_NORM;
			S_NORM:  if (root_q[ROOT_W-1:MANT_W] == '0) state_d = S_RD;
			S_RD:    state_d = S_MUL;
			S_MUL:   state_d = S_OUT;
			S_OUT:   if (out_load) state_d = is_last ? S_IDLE : S_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(HEAD_MAX);
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			n_q         <= '0;
			iter_q      <= '0;
			sh_q        <= '0;
			mant_q      <= '0;
			rem_q       <= '0;
			q_q         <= '0;
			root_q      <= '0;
			prod_q      <= '0;
			neg_q       <= 1'b0;
			out_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_q <= elems_per_head;
			end
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						sum_q <= sum_q + SUM_W'(32'(mag_in) * 32'(mag_in));
						if (closes) begin
							n_q     <= {1'b0, count_q} + LEN_W'(1);
							count_q <= '0;
						end else begin
							count_q <= count_q + IDX_W'(1);
						end
					end
				end
				S_CHECK: begin
					idx_q  <= '0;
					sh_q   <= '0;
					mant_q <= '0;
					iter_q <= 6'd62;
					rem_q  <= '0;
					q_q    <= {1'b0, n_q, 56'b0};
					if (sum_q == '0) begin
						sum_q <= '0;
					end
				end
				S_DIV: begin
					q_q    <= {1'b0, q_q[QUO_W-3:0], ~borrow};
					if (iter_q == '0) begin
						// start the root from a clean remainder
						rem_q  <= '0;
						iter_q <= 6'd31;
						root_q <= '0;
					end else begin
						rem_q  <= borrow ? sub_a[SUM_W-1:0] : diff[SUM_W-1:0];
						iter_q <= iter_q - 6'd1;
					end
				end
				S_SQRT: begin
					if (iter_q == 6'd31) begin
						rem_q <= borrow ? {2'b0, sub_a[34:0]} : {2'b0, diff[34:0]};
					end else begin
						rem_q <= borrow ? sub_a[SUM_W-1:0] : diff[SUM_W-1:0];
					end
					root_q <= {root_q[ROOT_W-2:0], ~borrow};
					q_q    <= {q_q[QUO_W-3:0], 2'b00};
					iter_q <= iter_q - 6'd1;
				end
				S_NORM: begin
					// drop low bits until the root fits the mantissa
					if (root_q[ROOT_W-1:MANT_W] != '0) begin
						root_q <= root_q >> 1;
						sh_q   <= sh_q + SH_W'(1);
					end else begin
						mant_q <= root_q[MANT_W-1:0];
						sum_q  <= '0;
					end
				end
				S_RD: begin
				end
				S_MUL: begin
					neg_q  <= rdata[ELEM_W-1];
					prod_q <= PROD_W'(rd_mag) * PROD_W'(mant_q);
				end
				S_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_q       <= val;
						last_q      <= is_last;
						idx_q       <= idx_q + IDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	a_sh_range: assert property (@(posedge clk) disable iff (!arst_n)
		sh_q <= SH_W'(13))
		else $error("scale shift out of range");

	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQRT) |-> (rem_q[SUM_W-1:35] == '0))
		else $error("root remainder too wide");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && is_last) |=> (state_q == S_IDLE && out_valid && last_of_head))
		else $error("head did not close after last result");

	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input taken while head in progress");
endmodule
